// ===== hdl/cmfa_pkg.sv =====
// Shared constants, widths and code points of the color/motion frame analyzer.
package cmfa_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // shared divider and root unit widths, sized for the largest frame
   localparam int DIV_NUM_W = 56;
   localparam int DIV_DEN_W = 40;
   localparam int SQ_W      = 34;
   localparam int SQ_RES_W  = 17;
   localparam int NPW       = 18;  // w*h of the 9-bit size registers
   localparam int SCW       = 40;  // sub-score difference width

   // csr register indexes
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_FRAME_RATE   = 3'd2;
   localparam logic [2:0] CSR_MOTION_THR   = 3'd3;
   localparam logic [2:0] CSR_RUN_THR      = 3'd4;
   localparam logic [2:0] CSR_MIN_RUN      = 3'd5;

   localparam logic [8:0]  RST_FRAME_WIDTH  = 9'd256;
   localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd256;
   localparam logic [15:0] RST_FRAME_RATE   = 16'd7680;
   localparam logic [7:0]  RST_MOTION_THR   = 8'd28;
   localparam logic [15:0] RST_RUN_THR      = 16'd27525;
   localparam logic [3:0]  RST_MIN_RUN      = 4'd2;

   // luma = floor((299r + 587g + 114b) / 1000) via reciprocal and one fixup
   localparam int LUMA_R      = 299;
   localparam int LUMA_G      = 587;
   localparam int LUMA_B      = 114;
   localparam int LUMA_DIV    = 1000;
   localparam int LUMA_RECIP  = 33555;
   localparam int LUMA_SHIFT  = 25;

   // score terms
   localparam int SC_SCALE = 1000;
   localparam int M_OFF = 12, M_DEN = 120;
   localparam int D_OFF = 18, D_DEN = 160;
   localparam int O_OFF = 2,  O_DEN = 45;
   localparam int W_M = 25, W_D = 20, W_O = 35, W_S = 20, SC_DIV = 100;
   localparam int SS_MUL = 20, SS_DIV = 11;
   localparam int QUAL_NUM = 3;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ===== hdl/cmfa_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module cmfa_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [cmfa_pkg::DIV_NUM_W-1:0]    num,
   input  logic [cmfa_pkg::DIV_DEN_W-1:0]    den,
   output logic [cmfa_pkg::DIV_NUM_W-1:0]    quot,
   output cmfa_pkg::unit_status_type         status
);
   import cmfa_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in, rem_sh;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic                 done_ff, done_in;

   always_comb begin
      rem_sh   = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      if (start) begin
         count_in = CNT_W'(DIV_NUM_W);
         rem_in   = '0;
         quo_in   = num;
         den_in   = den;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         done_in = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quot        = quo_ff;
   assign status.done = done_ff;
   assign status.busy = (count_ff != '0);

endmodule

// ===== hdl/cmfa_isqrt.sv =====
// Bit-pair integer square root, one result bit per cycle.
module cmfa_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cmfa_pkg::SQ_W-1:0]      radicand,
   output logic [cmfa_pkg::SQ_RES_W-1:0]  root,
   output cmfa_pkg::unit_status_type      status
);
   import cmfa_pkg::*;

   logic [SQ_W-1:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [SQ_W:0]   trial;
   logic            done_ff, done_in;

   always_comb begin
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      if (start) begin
         v_in   = radicand;
         res_in = '0;
         bit_in = SQ_W'(1) << (SQ_W - 2);
      end else if (bit_ff != '0) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in   = SQ_W'({1'b0, v_ff} - trial);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         done_in = (bit_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
   end

   assign root        = res_ff[SQ_RES_W-1:0];
   assign status.done = done_ff;
   assign status.busy = (bit_ff != '0);

endmodule

// ===== hdl/color_motion_frame_analyzer_top.sv =====
// Top level of the color/motion frame analyzer: pixel path, frame sequencer, shared units.
//
// Pixels come in raster order, one beat each, and a beat passes four steps: capture, luma
// sum and previous-luma read, reciprocal multiply, then mask/motion/accumulate and the
// write back of the new luma into the frame store (one read and one write port). The block
// drops req_tready from capture until the write back. On the last pixel of a frame the
// sequencer runs up to ten divisions through one shared restoring divider (three ratios,
// two centroid coordinates when any moving masked pixel exists, three sub-scores, the
// speed term and the score) plus a square root when this frame and a previous one both
// have a centroid. The result beat then waits in an output register until rsp_tready.
// The luma store is not cleared: new_clip only clears flags and counters, and the first
// frame of a clip ignores what it reads from it.
// frame_width/height of 0 act as 1, larger than MAX_* act as MAX_*.
module color_motion_frame_analyzer_top #(
   parameter int MAX_WIDTH  = cmfa_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cmfa_pkg::DEF_MAX_HEIGHT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic         req_tuser,   // new_clip
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // frame_index[15:0], motion_ratio[31:16], mask_ratio[47:32], moving_mask_ratio[63:48],
   // center_valid[64], center_x[80:65], center_y[96:81], speed[121:97],
   // frame_score[137:122], running[138], zero pad[143:139]
   output logic [143:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import cmfa_pkg::*;

   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);
   localparam int SW    = NW + ((CW > RW) ? CW : RW);

   localparam logic [3:0] ST_IDLE = 4'd0, ST_P0 = 4'd1, ST_P1 = 4'd2, ST_P2 = 4'd3,
                          ST_N = 4'd4, ST_DSET = 4'd5, ST_DWAIT = 4'd6, ST_SQ0 = 4'd7,
                          ST_SQ1 = 4'd8, ST_SQW = 4'd9, ST_SPD = 4'd10, ST_FIN = 4'd11,
                          ST_OUT = 4'd12;

   localparam logic [3:0] STEP_MOT = 4'd0, STEP_MSK = 4'd1, STEP_MMR = 4'd2, STEP_CX = 4'd3,
                          STEP_CY = 4'd4, STEP_MS = 4'd5, STEP_DS = 4'd6, STEP_OS = 4'd7,
                          STEP_SS = 4'd8, STEP_SCORE = 4'd9;

   // config
   logic [8:0]  cfg_w_ff, cfg_h_ff;
   logic [15:0] cfg_fr_ff, cfg_rthr_ff;
   logic [7:0]  cfg_mthr_ff;
   logic [3:0]  cfg_minrun_ff;

   // control / frame state
   logic [3:0]  state_ff, step_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [NW-1:0] mask_cnt_ff, mov_cnt_ff, mm_cnt_ff;
   logic [SW-1:0] sumc_ff, sumr_ff;
   logic        have_prev_ff, last_valid_ff;
   logic [15:0] last_x_ff, last_y_ff, frame_ff;
   logic [3:0]  run_ff;

   // pixel path
   logic [7:0]  r_ff, g_ff, b_ff;
   logic [17:0] x_ff;
   logic [8:0]  q0_ff;
   logic [7:0]  rd_ff;
   logic [7:0]  store_mem [DEPTH];

   // frame results
   logic [NPW-1:0] n_ff;
   logic [15:0] mot_ff, msk_ff, mmr_ff, cx_ff, cy_ff, score_ff;
   logic [24:0] speed_ff;
   logic [16:0] ms_ff, ds_ff, os_ff, ss_ff;
   logic [31:0] dx2_ff, dy2_ff;
   logic [143:0] rsp_data_ff;

   // shared units
   logic                 div_start, sq_start;
   logic [DIV_NUM_W-1:0] div_num, div_q;
   logic [DIV_DEN_W-1:0] div_den;
   unit_status_type      div_st, sq_st;
   logic [SQ_RES_W-1:0]  sq_root;

   // combinational helpers
   logic [8:0]  w_eff, h_eff;
   logic [AW-1:0] addr;
   logic [8:0]  luma9;
   logic [7:0]  luma, mx, mn, chroma, diff;
   logic        mask, moving, last_col, last_row, valid;
   logic [NW-1:0] sc_cnt;
   logic [7:0]  sc_off, sc_den;
   logic [SCW-1:0] sc_a, sc_b, sc_diff;
   logic [16:0] adx, ady;
   logic [32:0] spd_prod;
   logic        qualifies;
   logic [3:0]  run_next;

   function automatic logic [15:0] sat16(input logic [DIV_NUM_W-1:0] v);
      return (v > DIV_NUM_W'(65535)) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [16:0] sat17(input logic [DIV_NUM_W-1:0] v);
      return (v > DIV_NUM_W'(65536)) ? 17'd65536 : v[16:0];
   endfunction

   // effective frame size
   always_comb begin
      if (cfg_w_ff == '0) w_eff = 9'd1;
      else if (32'(cfg_w_ff) > MAX_WIDTH) w_eff = 9'(MAX_WIDTH);
      else w_eff = cfg_w_ff;
      if (cfg_h_ff == '0) h_eff = 9'd1;
      else if (32'(cfg_h_ff) > MAX_HEIGHT) h_eff = 9'(MAX_HEIGHT);
      else h_eff = cfg_h_ff;
   end

   assign addr     = AW'(32'(row_ff) * MAX_WIDTH + 32'(col_ff));
   assign last_col = !(32'(col_ff) + 32'd1 < 32'(w_eff));
   assign last_row = !(32'(row_ff) + 32'd1 < 32'(h_eff));
   assign valid    = (mm_cnt_ff != '0);

   // luma fixup, chroma, mask, motion
   always_comb begin
      luma9 = (18'(q0_ff) * 18'(LUMA_DIV) > x_ff) ? q0_ff - 9'd1 : q0_ff;
      luma  = luma9[7:0];
      mx = (r_ff > g_ff) ? r_ff : g_ff;
      if (b_ff > mx) mx = b_ff;
      mn = (r_ff < g_ff) ? r_ff : g_ff;
      if (b_ff < mn) mn = b_ff;
      chroma = mx - mn;
      mask = (r_ff > 8'd60 && g_ff > 8'd35 && r_ff >= g_ff && g_ff >= b_ff && chroma > 8'd20)
          || (luma < 8'd65 && chroma < 8'd45) || (luma > 8'd185 && chroma < 8'd35);
      diff   = (luma > rd_ff) ? luma - rd_ff : rd_ff - luma;
      moving = have_prev_ff && (diff > cfg_mthr_ff);
   end

   // divider operand select
   always_comb begin
      sc_cnt = mov_cnt_ff;
      sc_off = 8'(M_OFF);
      sc_den = 8'(M_DEN);
      case (step_ff)
         STEP_DS: begin
            sc_cnt = mask_cnt_ff; sc_off = 8'(D_OFF); sc_den = 8'(D_DEN);
         end
         STEP_OS: begin
            sc_cnt = mm_cnt_ff; sc_off = 8'(O_OFF); sc_den = 8'(O_DEN);
         end
         default: ;
      endcase
      sc_a    = SCW'(sc_cnt) * SCW'(SC_SCALE);
      sc_b    = SCW'(n_ff) * SCW'(sc_off);
      sc_diff = sc_a - sc_b;

      div_num = '0;
      div_den = DIV_DEN_W'(n_ff);
      case (step_ff)
         STEP_MOT: div_num = DIV_NUM_W'({mov_cnt_ff, 16'd0});
         STEP_MSK: div_num = DIV_NUM_W'({mask_cnt_ff, 16'd0});
         STEP_MMR: div_num = DIV_NUM_W'({mm_cnt_ff, 16'd0});
         STEP_CX: begin
            div_num = DIV_NUM_W'({sumc_ff, 16'd0});
            div_den = DIV_DEN_W'(mm_cnt_ff) * DIV_DEN_W'(w_eff);
         end
         STEP_CY: begin
            div_num = DIV_NUM_W'({sumr_ff, 16'd0});
            div_den = DIV_DEN_W'(mm_cnt_ff) * DIV_DEN_W'(h_eff);
         end
         STEP_MS, STEP_DS, STEP_OS: begin
            div_num = (sc_a > sc_b) ? DIV_NUM_W'({sc_diff, 16'd0}) : '0;
            div_den = DIV_DEN_W'(n_ff) * DIV_DEN_W'(sc_den);
         end
         STEP_SS: begin
            div_num = DIV_NUM_W'(speed_ff) * DIV_NUM_W'(SS_MUL);
            div_den = DIV_DEN_W'(SS_DIV);
         end
         STEP_SCORE: begin
            div_num = DIV_NUM_W'(ms_ff) * DIV_NUM_W'(W_M) + DIV_NUM_W'(ds_ff) * DIV_NUM_W'(W_D)
                    + DIV_NUM_W'(os_ff) * DIV_NUM_W'(W_O) + DIV_NUM_W'(ss_ff) * DIV_NUM_W'(W_S);
            div_den = DIV_DEN_W'(SC_DIV);
         end
         default: ;
      endcase
   end

   assign div_start = (state_ff == ST_DSET);
   assign sq_start  = (state_ff == ST_SQ1);

   // centroid step and speed
   always_comb begin
      adx = (cx_ff > last_x_ff) ? 17'(cx_ff - last_x_ff) : 17'(last_x_ff - cx_ff);
      ady = (cy_ff > last_y_ff) ? 17'(cy_ff - last_y_ff) : 17'(last_y_ff - cy_ff);
      spd_prod  = 33'(sq_root) * 33'(cfg_fr_ff);
      qualifies = (score_ff >= cfg_rthr_ff)
               && (32'(mm_cnt_ff) * 32'(SC_SCALE) >= 32'(n_ff) * 32'(QUAL_NUM));
      if (!qualifies) run_next = 4'd0;
      else if (run_ff != 4'd15) run_next = run_ff + 4'd1;
      else run_next = run_ff;
   end

   cmfa_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quot   (div_q),
      .status (div_st)
   );

   cmfa_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (SQ_W'(dx2_ff) + SQ_W'(dy2_ff)),
      .root     (sq_root),
      .status   (sq_st)
   );

   // previous-frame luma store: read in P0, write back in P2
   always_ff @(posedge clock) begin
      if (state_ff == ST_P0) rd_ff <= store_mem[addr];
      if (state_ff == ST_P2) store_mem[addr] <= luma;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff      <= RST_FRAME_WIDTH;
         cfg_h_ff      <= RST_FRAME_HEIGHT;
         cfg_fr_ff     <= RST_FRAME_RATE;
         cfg_mthr_ff   <= RST_MOTION_THR;
         cfg_rthr_ff   <= RST_RUN_THR;
         cfg_minrun_ff <= RST_MIN_RUN;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_w_ff      <= csr_data[8:0];
            CSR_FRAME_HEIGHT: cfg_h_ff      <= csr_data[8:0];
            CSR_FRAME_RATE:   cfg_fr_ff     <= csr_data;
            CSR_MOTION_THR:   cfg_mthr_ff   <= csr_data[7:0];
            CSR_RUN_THR:      cfg_rthr_ff   <= csr_data;
            CSR_MIN_RUN:      cfg_minrun_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_MOT;
         col_ff        <= '0;
         row_ff        <= '0;
         mask_cnt_ff   <= '0;
         mov_cnt_ff    <= '0;
         mm_cnt_ff     <= '0;
         sumc_ff       <= '0;
         sumr_ff       <= '0;
         have_prev_ff  <= 1'b0;
         last_valid_ff <= 1'b0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         run_ff        <= '0;
         frame_ff      <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  r_ff <= req_tdata[7:0];
                  g_ff <= req_tdata[15:8];
                  b_ff <= req_tdata[23:16];
                  if (req_tuser) begin
                     col_ff <= '0; row_ff <= '0;
                     mask_cnt_ff <= '0; mov_cnt_ff <= '0; mm_cnt_ff <= '0;
                     sumc_ff <= '0; sumr_ff <= '0;
                     have_prev_ff <= 1'b0; last_valid_ff <= 1'b0;
                     run_ff <= '0; frame_ff <= '0;
                  end
                  state_ff <= ST_P0;
               end
            end
            ST_P0: begin
               x_ff <= 18'(r_ff) * 18'(LUMA_R) + 18'(g_ff) * 18'(LUMA_G)
                     + 18'(b_ff) * 18'(LUMA_B);
               state_ff <= ST_P1;
            end
            ST_P1: begin
               q0_ff    <= 9'((34'(x_ff) * 34'(LUMA_RECIP)) >> LUMA_SHIFT);
               state_ff <= ST_P2;
            end
            ST_P2: begin
               if (mask) mask_cnt_ff <= mask_cnt_ff + 1'b1;
               if (moving) mov_cnt_ff <= mov_cnt_ff + 1'b1;
               if (mask && moving) begin
                  mm_cnt_ff <= mm_cnt_ff + 1'b1;
                  sumc_ff   <= sumc_ff + SW'(col_ff);
                  sumr_ff   <= sumr_ff + SW'(row_ff);
               end
               if (!last_col) begin
                  col_ff   <= col_ff + 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  col_ff <= '0;
                  if (!last_row) begin
                     row_ff   <= row_ff + 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff   <= '0;
                     state_ff <= ST_N;
                  end
               end
            end
            ST_N: begin
               n_ff     <= NPW'(w_eff) * NPW'(h_eff);
               cx_ff    <= '0;
               cy_ff    <= '0;
               speed_ff <= '0;
               step_ff  <= STEP_MOT;
               state_ff <= ST_DSET;
            end
            ST_DSET: state_ff <= ST_DWAIT;
            ST_DWAIT: begin
               if (div_st.done) begin
                  state_ff <= ST_DSET;
                  step_ff  <= step_ff + 4'd1;
                  case (step_ff)
                     STEP_MOT: mot_ff <= sat16(div_q);
                     STEP_MSK: msk_ff <= sat16(div_q);
                     STEP_MMR: begin
                        mmr_ff <= sat16(div_q);
                        if (!valid) step_ff <= STEP_MS;
                     end
                     STEP_CX: cx_ff <= sat16(div_q);
                     STEP_CY: begin
                        cy_ff <= sat16(div_q);
                        if (last_valid_ff) state_ff <= ST_SQ0;
                     end
                     STEP_MS: ms_ff <= sat17(div_q);
                     STEP_DS: ds_ff <= sat17(div_q);
                     STEP_OS: os_ff <= sat17(div_q);
                     STEP_SS: ss_ff <= sat17(div_q);
                     STEP_SCORE: begin
                        score_ff <= sat16(div_q);
                        state_ff <= ST_FIN;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SQ0: begin
               dx2_ff   <= 32'(adx[15:0]) * 32'(adx[15:0]);
               dy2_ff   <= 32'(ady[15:0]) * 32'(ady[15:0]);
               state_ff <= ST_SQ1;
            end
            ST_SQ1: state_ff <= ST_SQW;
            ST_SQW: if (sq_st.done) state_ff <= ST_SPD;
            ST_SPD: begin
               speed_ff <= (spd_prod[32:8] > 25'h1FFFFFF) ? 25'h1FFFFFF : spd_prod[32:8];
               state_ff <= ST_DSET;
            end
            ST_FIN: begin
               run_ff <= run_next;
               rsp_data_ff <= {5'd0, (run_next >= cfg_minrun_ff), score_ff, speed_ff,
                               cy_ff, cx_ff, valid, mmr_ff, msk_ff, mot_ff, frame_ff};
               if (valid) begin
                  last_valid_ff <= 1'b1;
                  last_x_ff     <= cx_ff;
                  last_y_ff     <= cy_ff;
               end
               frame_ff     <= frame_ff + 16'd1;
               have_prev_ff <= 1'b1;
               mask_cnt_ff  <= '0;
               mov_cnt_ff   <= '0;
               mm_cnt_ff    <= '0;
               sumc_ff      <= '0;
               sumr_ff      <= '0;
               state_ff     <= ST_OUT;
            end
            ST_OUT: if (rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

// ===== hdl/cmfa_checker.sv =====
// Port-level checks of the frame analyzer, bound to the top level.
module cmfa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [23:0]  req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [2:0]   csr_index,
   input logic [15:0]  csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("pixel taken while a result beat is pending");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("pixel path not busy after a pixel beat");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind color_motion_frame_analyzer_top cmfa_checker u_cmfa_checker (.*);
